FILE: design/dmwbc_pkg.sv
// Shared types and default sizes for the direct-mapped write-back cache unit.
package dmwbc_pkg;

    localparam int NUM_LINES_DEF   = 8;
    localparam int BLOCK_BYTES_DEF = 8;
    localparam int NUM_REGS_DEF    = 16;
    localparam int ADDR_BITS_DEF   = 16;

    localparam int REG_FIELD_W   = 4;
    localparam int BYTE_W        = 8;
    localparam int HALF_W        = 16;

    typedef enum logic [1:0] {
        KIND_LOAD    = 2'd0,
        KIND_STORE   = 2'd1,
        KIND_PRELOAD = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

endpackage

FILE: design/direct_mapped_write_back_cache_unit.sv
// Top level: cache sequencer, tag store, register file and the two data RAMs.
// Preload and undefined kinds go straight to the result; a hit goes to the access step, a clean miss
// first refills the line, and a dirty miss first writes the victim line back and then refills it.
// One item at a time: s_tready stays low until its result is in the output slot; blocks move byte by byte.
// After reset the backing memory is swept to zero, all 2^ADDR_BITS addresses, with s_tready low.
// Reset clears the register file, line valid, dirty and tag state and the output slot.
module direct_mapped_write_back_cache_unit #(
    parameter int NUM_LINES   = dmwbc_pkg::NUM_LINES_DEF,
    parameter int BLOCK_BYTES = dmwbc_pkg::BLOCK_BYTES_DEF,
    parameter int NUM_REGS    = dmwbc_pkg::NUM_REGS_DEF,
    parameter int ADDR_BITS   = dmwbc_pkg::ADDR_BITS_DEF,
    localparam int S_DATA_W   = ((dmwbc_pkg::REG_FIELD_W + ADDR_BITS + dmwbc_pkg::BYTE_W + 7) / 8) * 8,
    localparam int OFF_W      = $clog2(BLOCK_BYTES),
    localparam int IDX_W      = $clog2(NUM_LINES),
    localparam int TAG_W      = ADDR_BITS - OFF_W - IDX_W,
    localparam int M_DATA_W   = ((1 + TAG_W + IDX_W + OFF_W + dmwbc_pkg::HALF_W + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // reg_index, address, preload_byte
    input  logic [1:0]          s_tuser,   // kind
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // hit, tag_out, line_index, byte_offset, moved_value
);

    import dmwbc_pkg::*;

    localparam int RIDX_W = $clog2(NUM_REGS);
    localparam int CNT_W  = OFF_W + 1;
    localparam int LA_W   = IDX_W + OFF_W;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WB,
        ST_FILL,
        ST_ACCESS,
        ST_RESULT
    } state_t;

    state_t                  state_reg;
    kind_t                   kind_reg;
    logic [RIDX_W-1:0]       ridx_reg;
    logic [TAG_W-1:0]        tag_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic [OFF_W-1:0]        off_reg;
    logic                    hit_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [HALF_W-1:0]       val_reg;
    logic [ADDR_BITS-1:0]    clr_cnt_reg;
    logic                    line_valid_reg [NUM_LINES];
    logic                    line_dirty_reg [NUM_LINES];
    logic [TAG_W-1:0]        line_tag_reg   [NUM_LINES];
    logic [HALF_W-1:0]       regs_reg       [NUM_REGS];
    logic                    m_tvalid_reg;
    logic [M_DATA_W-1:0]     m_tdata_reg;

    logic [RIDX_W-1:0]       reg_map [1 << REG_FIELD_W];
    kind_t                   in_kind;
    logic [REG_FIELD_W-1:0]  in_reg;
    logic [ADDR_BITS-1:0]    in_addr;
    logic [BYTE_W-1:0]       in_pbyte;
    logic [OFF_W-1:0]        in_off;
    logic [IDX_W-1:0]        in_idx;
    logic [TAG_W-1:0]        in_tag;
    logic                    in_hit;
    logic                    in_dirty_victim;
    logic                    accept;
    logic [CNT_W-1:0]        cnt_prev;
    logic [LA_W-1:0]         acc_addr;

    logic                    mem_we;
    logic [ADDR_BITS-1:0]    mem_waddr;
    logic [BYTE_W-1:0]       mem_wdata;
    logic [ADDR_BITS-1:0]    mem_raddr;
    logic [BYTE_W-1:0]       mem_rdata;
    logic                    line_we;
    logic [LA_W-1:0]         line_waddr;
    logic [BYTE_W-1:0]       line_wdata;
    logic [LA_W-1:0]         line_raddr;
    logic [BYTE_W-1:0]       line_rdata;

    for (genvar g = 0; g < (1 << REG_FIELD_W); g++) begin : g_reg_map
        assign reg_map[g] = RIDX_W'(g % NUM_REGS);
    end

    assign in_kind  = kind_t'(s_tuser);
    assign in_reg   = s_tdata[REG_FIELD_W-1:0];
    assign in_addr  = s_tdata[REG_FIELD_W +: ADDR_BITS];
    assign in_pbyte = s_tdata[REG_FIELD_W + ADDR_BITS +: BYTE_W];
    assign in_off   = in_addr[OFF_W-1:0] & ~OFF_W'(1);
    assign in_idx   = in_addr[OFF_W +: IDX_W];
    assign in_tag   = in_addr[ADDR_BITS-1 -: TAG_W];
    assign in_hit   = line_valid_reg[in_idx] && (line_tag_reg[in_idx] == in_tag);
    assign in_dirty_victim = line_valid_reg[in_idx] && line_dirty_reg[in_idx];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign cnt_prev = cnt_reg - CNT_W'(1);
    assign acc_addr = {idx_reg, off_reg} | LA_W'(cnt_reg[0]);

    always_comb begin
        mem_we     = 1'b0;
        mem_waddr  = clr_cnt_reg;
        mem_wdata  = '0;
        mem_raddr  = {tag_reg, idx_reg, cnt_reg[OFF_W-1:0]};
        line_we    = 1'b0;
        line_waddr = {idx_reg, cnt_prev[OFF_W-1:0]};
        line_wdata = mem_rdata;
        line_raddr = {idx_reg, cnt_reg[OFF_W-1:0]};
        unique case (state_reg)
            ST_CLEAR: begin
                mem_we = 1'b1;
            end
            ST_IDLE: begin
                if (accept && in_kind == KIND_PRELOAD) begin
                    mem_we    = 1'b1;
                    mem_waddr = in_addr;
                    mem_wdata = in_pbyte;
                end
            end
            ST_WB: begin
                if (cnt_reg != '0) begin
                    mem_we    = 1'b1;
                    mem_waddr = {line_tag_reg[idx_reg], idx_reg, cnt_prev[OFF_W-1:0]};
                    mem_wdata = line_rdata;
                end
            end
            ST_FILL: begin
                line_we = (cnt_reg != '0);
            end
            ST_ACCESS: begin
                line_raddr = acc_addr;
                line_waddr = acc_addr;
                line_wdata = cnt_reg[0] ? regs_reg[ridx_reg][BYTE_W-1:0]
                                        : regs_reg[ridx_reg][HALF_W-1:BYTE_W];
                line_we    = (kind_reg == KIND_STORE) && (cnt_reg < CNT_W'(2));
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < NUM_LINES; i++) begin
                line_valid_reg[i] <= 1'b0;
                line_dirty_reg[i] <= 1'b0;
                line_tag_reg[i]   <= '0;
            end
            for (int r = 0; r < NUM_REGS; r++) begin
                regs_reg[r] <= '0;
            end
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != ST_RESULT) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + ADDR_BITS'(1);
                    if (clr_cnt_reg == '1) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        kind_reg <= in_kind;
                        ridx_reg <= reg_map[in_reg];
                        tag_reg  <= in_tag;
                        idx_reg  <= in_idx;
                        off_reg  <= in_off;
                        cnt_reg  <= '0;
                        val_reg  <= '0;
                        hit_reg  <= 1'b0;
                        unique case (in_kind)
                            KIND_LOAD, KIND_STORE: begin
                                hit_reg <= in_hit;
                                if (in_hit) begin
                                    state_reg <= ST_ACCESS;
                                end else if (in_dirty_victim) begin
                                    state_reg <= ST_WB;
                                end else begin
                                    state_reg <= ST_FILL;
                                end
                            end
                            KIND_PRELOAD: begin
                                state_reg <= ST_RESULT;
                            end
                            default: begin
                                tag_reg   <= '0;
                                idx_reg   <= '0;
                                off_reg   <= '0;
                                state_reg <= ST_RESULT;
                            end
                        endcase
                    end
                end
                ST_WB: begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(BLOCK_BYTES)) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_FILL;
                    end
                end
                ST_FILL: begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(BLOCK_BYTES)) begin
                        cnt_reg                 <= '0;
                        line_valid_reg[idx_reg] <= 1'b1;
                        line_dirty_reg[idx_reg] <= 1'b0;
                        line_tag_reg[idx_reg]   <= tag_reg;
                        state_reg               <= ST_ACCESS;
                    end
                end
                ST_ACCESS: begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (kind_reg == KIND_LOAD) begin
                        if (cnt_reg == CNT_W'(1)) begin
                            val_reg[HALF_W-1:BYTE_W] <= line_rdata;
                        end
                        if (cnt_reg == CNT_W'(2)) begin
                            val_reg[BYTE_W-1:0] <= line_rdata;
                            regs_reg[ridx_reg]  <= {val_reg[HALF_W-1:BYTE_W], line_rdata};
                            state_reg           <= ST_RESULT;
                        end
                    end else begin
                        val_reg <= regs_reg[ridx_reg];
                        if (cnt_reg == CNT_W'(1)) begin
                            line_dirty_reg[idx_reg] <= 1'b1;
                            state_reg               <= ST_RESULT;
                        end
                    end
                end
                ST_RESULT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= M_DATA_W'({val_reg, off_reg, idx_reg, tag_reg, hit_reg});
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    dmwbc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (1 << ADDR_BITS)
    ) u_backing_ram (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    dmwbc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (NUM_LINES * BLOCK_BYTES)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (line_we),
        .wr_addr (line_waddr),
        .wr_data (line_wdata),
        .rd_addr (line_raddr),
        .rd_data (line_rdata)
    );

    a_fill_installs_line: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(state_reg) == ST_FILL && state_reg == ST_ACCESS) |->
        (line_valid_reg[idx_reg] && !line_dirty_reg[idx_reg] &&
         line_tag_reg[idx_reg] == tag_reg))
        else $error("refill did not install a clean valid line");

    a_hit_skips_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WB || state_reg == ST_FILL) |-> !hit_reg)
        else $error("block transfer started for a hit");

    a_store_marks_dirty: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(state_reg) == ST_ACCESS && state_reg == ST_RESULT &&
         kind_reg == KIND_STORE) |-> line_dirty_reg[idx_reg])
        else $error("store left its line clean");

    a_result_waits_for_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESULT && m_tvalid_reg && !m_tready) |=> state_reg == ST_RESULT)
        else $error("result dropped while the output slot was full");

endmodule

FILE: design/dmwbc_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module dmwbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
